FILE: src/dwmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwmd_pkg - shared constants for the distinct window marker detector
// Field widths of the stream payloads and the reset value of the window size
// register.
// ----------------------------------------------------------------------------
package dwmd_pkg;

   // stream payload and window size register widths
   localparam int SYMBOL_W     = 8;
   localparam int POSITION_W   = 24;
   localparam int CSR_W        = 5;

   // window size after reset
   localparam int WINDOW_RESET = 4;

   typedef logic [SYMBOL_W-1:0] symbol_type;

endpackage

FILE: src/dwmd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwmd_cell - one stage of the symbol history chain
// Holds one past byte, passes it to the next stage on each shift and compares
// it against the incoming byte while it lies inside the current distinct run.
// ----------------------------------------------------------------------------
module dwmd_cell #(
   parameter int INDEX = 0,
   parameter int RUN_W = 5
) (
   input  logic                 clock,
   input  logic                 shift_en,
   input  dwmd_pkg::symbol_type sym_in,    // byte from the previous stage
   input  dwmd_pkg::symbol_type probe,     // byte of the incoming transaction
   input  logic [RUN_W-1:0]     run_len,   // length of the distinct suffix
   output dwmd_pkg::symbol_type sym_out,
   output logic                 hit
);

   dwmd_pkg::symbol_type byte_ff;
   dwmd_pkg::symbol_type byte_in;

   // shift the history one place whenever shift_en is high
   always_comb begin
      byte_in = shift_en ? sym_in : byte_ff;
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   // only stages inside the distinct run count as a repeat
   assign hit     = (byte_ff == probe) && (RUN_W'(INDEX) < run_len);
   assign sym_out = byte_ff;

endmodule

FILE: src/distinct_window_marker_detect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distinct_window_marker_detect - sliding window all-distinct marker finder
// Finds the first byte of a message at which the trailing window bytes are
// all different and reports its position.
// ----------------------------------------------------------------------------
// The block takes one byte per clock and never stalls its input unless a
// result sits unread in the output register while the sink holds rsp_tready
// low; a result is registered and appears in the cycle after the byte that
// causes it. A chain of MAX_WINDOW history stages compares the incoming byte
// with every stored byte in the same cycle, and a run counter tracks how many
// trailing bytes are all distinct. A message gives one result:
// found set with the 1-based position of the byte that completes the window,
// or, if the message ends first, found clear with the message length plus
// one. Bytes after a match are dropped up to tlast. The window size register
// takes 0 as 1 and clamps values above MAX_WINDOW; writing it restarts the
// message. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module distinct_window_marker_detect #(
   parameter int MAX_WINDOW    = 16,
   parameter int POSITION_BITS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_wr_en,
   input  logic [dwmd_pkg::CSR_W-1:0]      csr_wr_data,    // window_size
   // byte stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dwmd_pkg::SYMBOL_W-1:0]   req_tdata,      // [7:0] symbol
   input  logic                            req_tlast,      // last
   // results
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dwmd_pkg::POSITION_W-1:0] rsp_tdata,      // [23:0] position
   output logic                            rsp_tuser       // [0] found
);

   localparam int RUN_W   = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W   = (RUN_W > dwmd_pkg::CSR_W) ? RUN_W : dwmd_pkg::CSR_W;
   localparam int WIDE_W  = (POSITION_BITS > dwmd_pkg::POSITION_W) ?
                            POSITION_BITS : dwmd_pkg::POSITION_W;
   localparam int WIN_RST = (dwmd_pkg::WINDOW_RESET > MAX_WINDOW) ?
                            MAX_WINDOW : dwmd_pkg::WINDOW_RESET;
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
   localparam logic [RUN_W-1:0]         RUN_MAX = RUN_W'(MAX_WINDOW);

   logic [RUN_W-1:0]         window_ff, window_in;
   logic [RUN_W-1:0]         run_ff, run_in;
   logic [POSITION_BITS-1:0] byte_index_ff, byte_index_in;
   logic                     marker_seen_ff, marker_seen_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [dwmd_pkg::POSITION_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic                     rsp_found_ff, rsp_found_in;

   logic                     accept;
   logic                     shift_en;
   logic [MAX_WINDOW-1:0]    hit_vec;
   dwmd_pkg::symbol_type     link [MAX_WINDOW];
   logic [RUN_W-1:0]         hit_pos;
   logic [RUN_W-1:0]         new_run;
   logic                     match;
   logic                     emit;
   logic [POSITION_BITS-1:0] index_inc1;
   logic [POSITION_BITS-1:0] index_inc2;
   logic [CMP_W-1:0]         csr_raw;
   logic [WIDE_W-1:0]        pos_wide;

   // handshake: the output register frees up as soon as the sink takes it
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign shift_en   = accept && !marker_seen_ff;

   // history chain, newest byte in stage 0
   for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
      dwmd_cell #(
         .INDEX (k),
         .RUN_W (RUN_W)
      ) u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .sym_in   ((k == 0) ? req_tdata : link[(k == 0) ? 0 : k - 1]),
         .probe    (req_tdata),
         .run_len  (run_ff),
         .sym_out  (link[k]),
         .hit      (hit_vec[k])
      );
   end

   // stages inside the run are distinct, so at most one hit: encode it
   always_comb begin
      hit_pos = '0;
      for (int k = 0; k < MAX_WINDOW; k++) begin
         if (hit_vec[k]) begin
            hit_pos = hit_pos | RUN_W'(k + 1);
         end
      end
   end

   // new distinct suffix length and match test
   always_comb begin
      if (|hit_vec) begin
         new_run = hit_pos;
      end else if (run_ff == RUN_MAX) begin
         new_run = RUN_MAX;
      end else begin
         new_run = run_ff + RUN_W'(1);
      end
      match = !marker_seen_ff && (new_run >= window_ff);
      emit  = !marker_seen_ff && (match || req_tlast);
   end

   // saturating position counts
   always_comb begin
      index_inc1 = (byte_index_ff == POS_MAX) ? POS_MAX :
                   byte_index_ff + POSITION_BITS'(1);
      index_inc2 = (byte_index_ff >= POS_MAX - POSITION_BITS'(1)) ? POS_MAX :
                   byte_index_ff + POSITION_BITS'(2);
   end

   // window size clamp on write
   always_comb begin
      csr_raw = CMP_W'(csr_wr_data);
      if (csr_raw == '0) begin
         window_in = RUN_W'(1);
      end else if (csr_raw > CMP_W'(MAX_WINDOW)) begin
         window_in = RUN_MAX;
      end else begin
         window_in = RUN_W'(csr_raw);
      end
   end

   // message state update
   always_comb begin
      priority if (csr_wr_en || (accept && req_tlast)) begin
         run_in         = '0;
         byte_index_in  = '0;
         marker_seen_in = 1'b0;
      end else if (shift_en) begin
         run_in         = new_run;
         byte_index_in  = index_inc1;
         marker_seen_in = match;
      end else begin
         run_in         = run_ff;
         byte_index_in  = byte_index_ff;
         marker_seen_in = marker_seen_ff;
      end
   end

   // result register
   always_comb begin
      pos_wide     = WIDE_W'(match ? index_inc1 : index_inc2);
      rsp_valid_in = (rsp_valid_ff && !rsp_tready) || (accept && emit);
      rsp_pos_in   = rsp_pos_ff;
      rsp_found_in = rsp_found_ff;
      if (accept && emit) begin
         rsp_pos_in   = pos_wide[dwmd_pkg::POSITION_W-1:0];
         rsp_found_in = match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= RUN_W'(WIN_RST);
         run_ff         <= '0;
         byte_index_ff  <= '0;
         marker_seen_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            window_ff <= window_in;
         end
         run_ff         <= run_in;
         byte_index_ff  <= byte_index_in;
         marker_seen_ff <= marker_seen_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pos_ff   <= rsp_pos_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pos_ff;
   assign rsp_tuser  = rsp_found_ff;

`ifndef SYNTHESIS
   // a repeat inside the distinct run can only sit in one stage
   a_single_hit : assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one history stage hit inside the run");

   // run never exceeds the history depth
   a_run_bound : assert property (@(posedge clock) disable iff (reset)
      run_ff <= RUN_MAX)
      else $error("distinct run longer than history");

   // a frozen message keeps a run that satisfies the window
   a_marker_run : assert property (@(posedge clock) disable iff (reset)
      marker_seen_ff |-> (run_ff >= window_ff))
      else $error("marker flagged without a full distinct window");

   // the end of a message restarts all message state
   a_last_clears : assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=>
         (run_ff == '0 && byte_index_ff == '0 && !marker_seen_ff))
      else $error("message state not cleared after last byte");
`endif

endmodule
